[rtl/core/pra_pkg.sv]
// shared codes and state type of the page run allocator
package pra_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADLEN  = 2'd2;
  localparam logic [1:0] ST_OVERLAP = 2'd3;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SC_RD  = 9'b000000010,
    S_SC_EV  = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_SD_RD  = 9'b000010000,
    S_SD_WR  = 9'b000100000,
    S_SU_RD  = 9'b001000000,
    S_SU_WR  = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_t;

endpackage

[rtl/core/page_run_allocator.sv]
// page run allocator: first-fit allocation over a sorted free run table
// The free runs sit in a table memory with one write port and one registered
// read port, one run per entry, kept sorted by start page. An item is taken when
// start is high and busy is low; its one result shows on out_alloc_page and
// out_status for the single cycle in which out_strobe is high, and it cannot be
// held off. An item with a zero page count, or a free that reaches past the last
// page, is answered without touching the table. Any other item scans the table,
// reading and then evaluating each stored run; an allocate stops at the first run
// that is long enough, and any other scan ends with a closing read. An exact-fit
// allocate, a free that joins both neighbours, or a free that adds a new run then
// moves each following entry, a read and then a write per entry, and ends with a
// closing step. Busy stays high through the scan and the moves, and out_strobe is
// high in the first cycle in which busy is low again. Entry zero is loaded while
// reset is held, so no clearing pass follows reset.
module page_run_allocator #(
  parameter int TOTAL_PAGES = 256,
  parameter int MAX_RUNS    = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_page_index,
  input  logic [8:0] in_page_count,
  output logic       out_strobe,
  output logic [7:0] out_alloc_page,
  output logic [1:0] out_status
);
  import pra_pkg::*;

  localparam int PW = $clog2(TOTAL_PAGES);
  localparam int LW = $clog2(TOTAL_PAGES + 1);
  localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int XW = ((LW > 10) ? LW : 10) + 1;
  localparam int EW = PW + LW;

  // run table
  logic [EW-1:0] run_mem [MAX_RUNS];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          cmd_r, cmd_nxt;
  logic [7:0]    page_r, page_nxt;
  logic [8:0]    count_r, count_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          have_next_r, have_next_nxt;
  logic          overlap_r, overlap_nxt;
  logic [PW-1:0] prev_start_r, prev_start_nxt;
  logic [LW-1:0] prev_len_r, prev_len_nxt;
  logic [PW-1:0] next_start_r, next_start_nxt;
  logic [LW-1:0] next_len_r, next_len_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [7:0]    out_page_r, out_page_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic [PW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic [XW-1:0] rs_x, re_x, rl_x, p_x, n_x, pend_x, newlen_x, apage_x, in_end_x;
  logic          join_prev, join_next;
  logic [CW-1:0] pos_m1, idx_p1, idx_m1;

  // table memory with registered read; entry zero loaded during reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mem[0] <= {PW'(0), LW'(TOTAL_PAGES)};
    end else if (mem_we) begin
      run_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= run_mem[rd_addr];
  end

  // datapath terms
  assign rd_start = rd_data_r[EW-1:LW];
  assign rd_len   = rd_data_r[LW-1:0];
  assign rs_x     = XW'(rd_start);
  assign rl_x     = XW'(rd_len);
  assign re_x     = rs_x + rl_x;
  assign p_x      = XW'(page_r);
  assign n_x      = XW'(count_r);
  assign pend_x   = p_x + n_x;
  assign newlen_x = rl_x - n_x;
  assign apage_x  = rs_x + newlen_x;
  assign in_end_x = XW'(in_page_index) + XW'(in_page_count);
  assign pos_m1   = pos_r - CW'(1);
  assign idx_p1   = idx_r + CW'(1);
  assign idx_m1   = idx_r - CW'(1);
  assign join_prev = have_prev_r && (XW'(prev_start_r) + XW'(prev_len_r) == p_x);
  assign join_next = have_next_r && (XW'(next_start_r) == pend_x);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    count_nxt      = count_r;
    have_prev_nxt  = have_prev_r;
    have_next_nxt  = have_next_r;
    overlap_nxt    = overlap_r;
    prev_start_nxt = prev_start_r;
    prev_len_nxt   = prev_len_r;
    next_start_nxt = next_start_r;
    next_len_nxt   = next_len_r;
    out_strobe_nxt = 1'b0;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    rd_addr        = idx_r[IW-1:0];
    mem_we         = 1'b0;
    mem_wa         = idx_r[IW-1:0];
    mem_wd         = rd_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = in_command;
          page_nxt      = in_page_index;
          count_nxt     = in_page_count;
          idx_nxt       = '0;
          pos_nxt       = cnt_r;
          have_prev_nxt = 1'b0;
          have_next_nxt = 1'b0;
          overlap_nxt   = 1'b0;
          out_page_nxt  = '0;
          if (in_page_count == 9'd0 ||
              (in_command == CMD_FREE && in_end_x > XW'(TOTAL_PAGES))) begin
            out_status_nxt = ST_BADLEN;
            out_strobe_nxt = 1'b1;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_RD: begin
        if (idx_r == cnt_r) begin
          if (cmd_r == CMD_ALLOC) begin
            out_status_nxt = ST_NOMEM;
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          state_nxt = S_SC_EV;
        end
      end
      S_SC_EV: begin
        if (cmd_r == CMD_ALLOC) begin
          if (rl_x == n_x) begin
            out_page_nxt   = 8'(rs_x);
            out_status_nxt = ST_OK;
            state_nxt      = S_SD_RD;
          end else if (rl_x > n_x) begin
            mem_we         = 1'b1;
            mem_wd         = {rd_start, LW'(newlen_x)};
            out_page_nxt   = apage_x[7:0];
            out_status_nxt = ST_OK;
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_SC_RD;
          end
        end else begin
          if (p_x < re_x && rs_x < pend_x) begin
            overlap_nxt = 1'b1;
          end
          if (rs_x < p_x) begin
            have_prev_nxt  = 1'b1;
            prev_start_nxt = rd_start;
            prev_len_nxt   = rd_len;
          end else if (!have_next_r) begin
            have_next_nxt  = 1'b1;
            next_start_nxt = rd_start;
            next_len_nxt   = rd_len;
            pos_nxt        = idx_r;
          end
          idx_nxt   = idx_p1;
          state_nxt = S_SC_RD;
        end
      end
      S_DECIDE: begin
        out_status_nxt = ST_OK;
        if (overlap_r) begin
          out_status_nxt = ST_OVERLAP;
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (join_prev && join_next) begin
          mem_we    = 1'b1;
          mem_wa    = pos_m1[IW-1:0];
          mem_wd    = {prev_start_r, LW'(XW'(prev_len_r) + n_x + XW'(next_len_r))};
          idx_nxt   = pos_r;
          state_nxt = S_SD_RD;
        end else if (join_prev) begin
          mem_we         = 1'b1;
          mem_wa         = pos_m1[IW-1:0];
          mem_wd         = {prev_start_r, LW'(XW'(prev_len_r) + n_x)};
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (join_next) begin
          mem_we         = 1'b1;
          mem_wa         = pos_r[IW-1:0];
          mem_wd         = {PW'(page_r), LW'(XW'(next_len_r) + n_x)};
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (cnt_r == CW'(MAX_RUNS)) begin
          out_status_nxt = ST_NOMEM;
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SU_RD;
        end
      end
      // close the gap at idx by pulling later entries down
      S_SD_RD: begin
        if (idx_p1 < cnt_r) begin
          rd_addr   = idx_p1[IW-1:0];
          state_nxt = S_SD_WR;
        end else begin
          cnt_nxt        = cnt_r - CW'(1);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SD_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[IW-1:0];
        mem_wd    = rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = S_SD_RD;
      end
      // open a slot at pos by pushing entries up, then fill it
      S_SU_RD: begin
        if (idx_r > pos_r) begin
          rd_addr   = idx_m1[IW-1:0];
          state_nxt = S_SU_WR;
        end else begin
          mem_we         = 1'b1;
          mem_wa         = pos_r[IW-1:0];
          mem_wd         = {PW'(page_r), LW'(count_r)};
          cnt_nxt        = cnt_r + CW'(1);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SU_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[IW-1:0];
        mem_wd    = rd_data_r;
        idx_nxt   = idx_m1;
        state_nxt = S_SU_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= CW'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    count_r      <= count_nxt;
    have_prev_r  <= have_prev_nxt;
    have_next_r  <= have_next_nxt;
    overlap_r    <= overlap_nxt;
    prev_start_r <= prev_start_nxt;
    prev_len_r   <= prev_len_nxt;
    next_start_r <= next_start_nxt;
    next_len_r   <= next_len_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_alloc_page = out_page_r;
  assign out_status     = out_status_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RUNS)) else $error("run count beyond table size");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> state_r == S_IDLE) else $error("result while still working");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r != ST_OK) |-> out_page_r == 8'd0)
    else $error("failed item gave a page");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_page_count != 9'd0 && in_command == CMD_ALLOC) |=> busy)
    else $error("allocate item not started");
`endif

endmodule

[verif/page_run_checker.sv]
// checker for the page run allocator: predicts each result and compares it
module page_run_checker #(
  parameter int TOTAL_PAGES = 256,
  parameter int MAX_RUNS    = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_page_index,
  input  logic [8:0] in_page_count,
  input  logic       out_strobe,
  input  logic [7:0] out_alloc_page,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending,
  output int         result_count
);
  import pra_pkg::*;

  typedef struct packed {
    logic [7:0] alloc_page;
    logic [1:0] status;
  } answer_t;

  // own copy of the free run table
  int run_start [MAX_RUNS];
  int run_len   [MAX_RUNS];
  int run_cnt;
  answer_t answers_due [$];
  int status_seen [4];

  function automatic void remove_run(int i);
    for (int k = i; k + 1 < run_cnt; k++) begin
      run_start[k] = run_start[k + 1];
      run_len[k]   = run_len[k + 1];
    end
    run_cnt--;
  endfunction

  // first fit, pages cut from the top of a longer run
  function automatic answer_t take_pages(int n);
    answer_t a;
    a.alloc_page = '0;
    a.status     = ST_NOMEM;
    if (n == 0) begin
      a.status = ST_BADLEN;
      return a;
    end
    for (int i = 0; i < run_cnt; i++) begin
      if (run_len[i] == n) begin
        a.alloc_page = run_start[i][7:0];
        a.status     = ST_OK;
        remove_run(i);
        return a;
      end
      if (run_len[i] > n) begin
        run_len[i]   = run_len[i] - n;
        a.alloc_page = 8'(run_start[i] + run_len[i]);
        a.status     = ST_OK;
        return a;
      end
    end
    return a;
  endfunction

  // sorted insert with merging into either neighbor
  function automatic answer_t give_pages(int p, int n);
    answer_t a;
    int pend, pos;
    bit jp, jn;
    a.alloc_page = '0;
    a.status     = ST_OK;
    pend = p + n;
    if (n == 0 || pend > TOTAL_PAGES) begin
      a.status = ST_BADLEN;
      return a;
    end
    for (int i = 0; i < run_cnt; i++)
      if (p < run_start[i] + run_len[i] && run_start[i] < pend) begin
        a.status = ST_OVERLAP;
        return a;
      end
    pos = 0;
    while (pos < run_cnt && run_start[pos] < p) pos++;
    jp = pos > 0 && run_start[pos - 1] + run_len[pos - 1] == p;
    jn = pos < run_cnt && run_start[pos] == pend;
    if (jp && jn) begin
      run_len[pos - 1] += n + run_len[pos];
      remove_run(pos);
    end else if (jp) begin
      run_len[pos - 1] += n;
    end else if (jn) begin
      run_start[pos] = p;
      run_len[pos] += n;
    end else begin
      if (run_cnt >= MAX_RUNS) begin
        a.status = ST_NOMEM;
        return a;
      end
      for (int k = run_cnt; k > pos; k--) begin
        run_start[k] = run_start[k - 1];
        run_len[k]   = run_len[k - 1];
      end
      run_start[pos] = p;
      run_len[pos]   = n;
      run_cnt++;
    end
    return a;
  endfunction

  initial begin
    fail_count   = 0;
    result_count = 0;
    pending      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (run_start[i]) begin
      run_start[i] = 0;
      run_len[i]   = 0;
    end
    run_len[0] = TOTAL_PAGES;
    run_cnt    = 1;
  end

  // sample mid-cycle: results of this cycle first, then the item taken at the next edge
  always @(negedge clk) begin
    answer_t want;
    if (rst_n && out_strobe) begin
      result_count++;
      status_seen[out_status]++;
      if (answers_due.size() == 0) begin
        $error("result with nothing expected: page %0d status %0d", out_alloc_page,
               out_status);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (out_alloc_page !== want.alloc_page) begin
          $error("alloc_page: expected %0d actual %0d", want.alloc_page, out_alloc_page);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      if (in_command == CMD_ALLOC) answers_due.push_back(take_pages(int'(in_page_count)));
      else answers_due.push_back(give_pages(int'(in_page_index), int'(in_page_count)));
    end
    pending = answers_due.size();
  end

endmodule

[verif/tb_page_run_allocator.sv]
// testbench top for the page run allocator: stimulus, timeout and verdict
module tb_page_run_allocator;
  import pra_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_command;
  logic [7:0] in_page_index;
  logic [8:0] in_page_count;
  logic       out_strobe;
  logic [7:0] out_alloc_page;
  logic [1:0] out_status;
  int         fail_count, pending, result_count;
  int         cycle_count = 0;
  int         items_sent, allocs_sent, frees_sent;

  // allocations granted so far, kept so that frees can return them
  int   held_page [$];
  int   held_size [$];
  logic sent_cmd  [$];
  int   sent_size [$];

  page_run_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_page_index(in_page_index),
    .in_page_count(in_page_count), .out_strobe(out_strobe),
    .out_alloc_page(out_alloc_page), .out_status(out_status)
  );

  page_run_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_page_index(in_page_index),
    .in_page_count(in_page_count), .out_strobe(out_strobe),
    .out_alloc_page(out_alloc_page), .out_status(out_status),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // record granted regions as their results go by
  always @(negedge clk) begin
    logic c;
    int   n;
    if (rst_n && out_strobe && sent_cmd.size() > 0) begin
      c = sent_cmd.pop_front();
      n = sent_size.pop_front();
      if (c == CMD_ALLOC && out_status == ST_OK) begin
        held_page.push_back(int'(out_alloc_page));
        held_size.push_back(n);
      end
    end
  end

  // one item: random gap, then hold start until busy is seen low mid-cycle
  task automatic send_item(logic cmd, int idx, int cnt);
    int gap;
    bit taken;
    gap = $urandom_range(3);
    if (($urandom_range(9)) < 3) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_page_index <= 8'(idx);
    in_page_count <= 9'(cnt);
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    sent_cmd.push_back(cmd);
    sent_size.push_back(cnt);
    items_sent++;
    if (cmd == CMD_ALLOC) allocs_sent++;
    else frees_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r, k, n;
    items_sent    = 0;
    allocs_sent   = 0;
    frees_sent    = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_ALLOC;
    in_page_index = '0;
    in_page_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad lengths, overlap, beyond memory, no fit, merges
    send_item(CMD_ALLOC, 0, 0);
    send_item(CMD_FREE, 5, 0);
    send_item(CMD_FREE, 0, 256);
    send_item(CMD_FREE, 255, 2);
    send_item(CMD_ALLOC, 0, 300);
    send_item(CMD_ALLOC, 255, 511);
    send_item(CMD_ALLOC, 0, 256);
    send_item(CMD_ALLOC, 0, 1);
    send_item(CMD_FREE, 255, 1);
    send_item(CMD_FREE, 0, 1);
    send_item(CMD_FREE, 1, 254);
    send_item(CMD_ALLOC, 0, 16);
    send_item(CMD_ALLOC, 0, 16);
    send_item(CMD_ALLOC, 0, 16);
    send_item(CMD_FREE, 240, 16);
    send_item(CMD_FREE, 208, 16);
    send_item(CMD_FREE, 224, 16);
    send_item(CMD_FREE, 208, 48);
    send_item(CMD_ALLOC, 0, 208);
    send_item(CMD_FREE, 100, 8);
    send_item(CMD_FREE, 92, 8);
    send_item(CMD_FREE, 108, 100);
    send_item(CMD_FREE, 0, 92);
    send_item(CMD_ALLOC, 170, 256);
    send_item(CMD_FREE, 0, 256);
    go_idle();
    held_page.delete();
    held_size.delete();

    // fragment the table to its full size of single page runs, then heal it
    for (k = 0; k < 256; k++) send_item(CMD_ALLOC, $urandom_range(255), 1);
    for (k = 0; k < 256; k += 2) send_item(CMD_FREE, k, 1);
    send_item(CMD_ALLOC, 0, 2);
    for (k = 1; k < 256; k += 2) send_item(CMD_FREE, k, 1);
    go_idle();
    held_page.delete();
    held_size.delete();

    // random: mostly allocations and returns of granted regions, some noise
    for (k = 0; k < 937; k++) begin
      if (k == 468) go_idle();
      r = $urandom_range(99);
      if (r < 40) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(256, 1) : $urandom_range(16, 1);
        send_item(CMD_ALLOC, $urandom_range(255), n);
      end else if (r < 80 && held_page.size() > 0) begin
        n = $urandom_range(held_page.size() - 1);
        send_item(CMD_FREE, held_page[n], held_size[n]);
        held_page.delete(n);
        held_size.delete(n);
      end else if (r < 90) begin
        send_item($urandom_range(1), $urandom_range(255), $urandom_range(511));
      end else begin
        send_item(CMD_FREE, $urandom_range(255), $urandom_range(24));
      end
    end

    go_idle();
    repeat (600) @(posedge clk);
    $display("covered %0d items (%0d allocate, %0d free), %0d results checked",
             items_sent, allocs_sent, frees_sent, result_count);
    $display("statuses seen: ok %0d, out of memory %0d, bad length %0d, overlap %0d",
             chk.status_seen[ST_OK], chk.status_seen[ST_NOMEM],
             chk.status_seen[ST_BADLEN], chk.status_seen[ST_OVERLAP]);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pra_pkg.sv
rtl/core/page_run_allocator.sv
verif/page_run_checker.sv
verif/tb_page_run_allocator.sv
